// ----- rtl/dhfa_pkg.sv -----
package dhfa_pkg;
	localparam int FRAC_BITS_DEF = 16;
	localparam int TAN_BITS = 30;
	localparam int OP_W = 1;
	localparam int ANG_W = 17;
	localparam int DH_W = 24;
	localparam int DIST_W = 40;
	localparam int HGT_W = 48;
	localparam int STAT_W = 2;
	localparam int NUM_W = 2 * TAN_BITS + 1;
	localparam logic [DH_W-1:0] DH_RESET = 24'd98304;

	typedef enum logic [STAT_W-1:0] {
		STAT_OK,
		STAT_ALPHA,
		STAT_BETA
	} status_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_TQ,
		ST_TT,
		ST_DIST,
		ST_MUL,
		ST_FIN
	} state_t;
endpackage

// ----- rtl/dhfa_if.sv -----
interface dhfa_req_if;
	import dhfa_pkg::*;
	logic valid;
	logic ready;
	logic [OP_W-1:0] opcode;
	logic [ANG_W-1:0] angle_alpha;
	logic [ANG_W-1:0] angle_beta;
	modport source (output valid, output opcode, output angle_alpha, output angle_beta,
		input ready);
	modport sink (input valid, input opcode, input angle_alpha, input angle_beta,
		output ready);
endinterface

interface dhfa_rsp_if;
	import dhfa_pkg::*;
	logic valid;
	logic ready;
	logic [DIST_W-1:0] distance;
	logic [HGT_W-1:0] height;
	logic [STAT_W-1:0] status;
	modport source (output valid, output distance, output height, output status,
		input ready);
	modport sink (input valid, input distance, input height, input status,
		output ready);
endinterface

interface dhfa_cfg_if;
	import dhfa_pkg::*;
	logic valid;
	logic ready;
	logic [DH_W-1:0] data;
	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

// ----- rtl/distance_height_from_angles.sv -----
// opcode 0 gives the distance from alpha; opcode 1 also runs beta and a shift-add
// product for the height; na, nb are term counts 3..10 per angle
// an out-of-range angle goes from idle straight to the finish state, with no division
// one request at a time; every division runs in the shared radix-2 divider
// reset clears control and sets device_height to 1.5 m; no memory clearing pass
module distance_height_from_angles (
	input  logic clk,
	input  logic arst_n,
	dhfa_cfg_if.sink cfg,
	dhfa_req_if.sink req,
	dhfa_rsp_if.source rsp
);
	import dhfa_pkg::*;

	localparam int FRAC_BITS = FRAC_BITS_DEF;
	localparam int QSH = FRAC_BITS + TAN_BITS;
	localparam int PW = DIST_W + NUM_W;
	localparam int CNT_W = $clog2(NUM_W + 1);
	localparam int MCNT_W = $clog2(DIST_W + 1);
	localparam logic [NUM_W-1:0] TAN_CAP = NUM_W'(1) << (2 * TAN_BITS);
	localparam logic [NUM_W-1:0] DIST_MAX = NUM_W'({DIST_W{1'b1}});
	localparam logic [PW-TAN_BITS-1:0] HGT_MAX_W = (PW-TAN_BITS)'({HGT_W{1'b1}});
	localparam logic [HGT_W-1:0] HGT_MAX = {HGT_W{1'b1}};
	localparam logic [63:0] BRK [9] = '{
		64'd0,
		(64'd21 << FRAC_BITS) / 64'd1000,
		(64'd106 << FRAC_BITS) / 64'd1000,
		(64'd275 << FRAC_BITS) / 64'd1000,
		(64'd520 << FRAC_BITS) / 64'd1000,
		(64'd814 << FRAC_BITS) / 64'd1000,
		(64'd1121 << FRAC_BITS) / 64'd1000,
		(64'd1387 << FRAC_BITS) / 64'd1000,
		(64'd1400 << FRAC_BITS) / 64'd1000
	};

	function automatic logic [3:0] term_count(input logic [ANG_W-1:0] a);
		logic [3:0] n;
		logic found;
		n = 4'd3;
		found = 1'b0;
		for (int i = 0; i < 8; i++) begin
			if (!found) begin
				if (64'(a) > BRK[i] && 64'(a) <= BRK[i+1])
					found = 1'b1;
				else
					n = n + 4'd1;
			end
		end
		return n;
	endfunction

	function automatic logic angle_ok(input logic [ANG_W-1:0] a);
		return a != '0 && 64'(a) <= BRK[8];
	endfunction

	state_t state_q, state_d;
	logic [DH_W-1:0] dh_q;
	logic [OP_W-1:0] op_q;
	logic [ANG_W-1:0] ang_q, beta_q;
	logic sel_q;
	logic [3:0] n_q;
	logic [4:0] v_q;
	logic [NUM_W-1:0] t_q;
	logic [DIST_W-1:0] dist_q;
	logic [HGT_W-1:0] hgt_q;
	status_t stat_q, stat_in;
	logic [DIST_W-1:0] rsp_dist_q;
	logic [HGT_W-1:0] rsp_hgt_q;
	logic [STAT_W-1:0] rsp_stat_q;
	logic rsp_valid_q;

	logic [NUM_W-1:0] div_num_q, div_den_q, div_rem_q, div_quo_q;
	logic [CNT_W-1:0] div_cnt_q;
	logic [NUM_W:0] rem_sh, rem_dif;
	logic div_ld, div_done;
	logic [NUM_W-1:0] div_num_d, div_den_d;

	logic [PW-1:0] acc_q;
	logic [DIST_W-1:0] mul_sh_q;
	logic [MCNT_W-1:0] mul_cnt_q;
	logic mul_ld;

	logic fin_tan, beta_go, rsp_go;
	logic [NUM_W-1:0] tn;
	logic [3:0] na, nb;
	logic [4:0] va, vb;
	logic [PW-TAN_BITS-1:0] p_full;
	logic [HGT_W-1:0] p48, hgt_calc;

	assign na = term_count(req.angle_alpha);
	assign va = {na, 1'b0} - 5'd1;
	assign nb = term_count(beta_q);
	assign vb = {nb, 1'b0} - 5'd1;
	assign div_done = div_cnt_q == '0;
	assign rsp_go = !rsp_valid_q || rsp.ready;

	always_comb begin
		if (!angle_ok(req.angle_alpha))
			stat_in = STAT_ALPHA;
		else if (req.opcode == 1'b1 && !angle_ok(req.angle_beta))
			stat_in = STAT_BETA;
		else
			stat_in = STAT_OK;
	end

	always_comb begin
		state_d = state_q;
		div_ld = 1'b0;
		div_num_d = '0;
		div_den_d = '0;
		mul_ld = 1'b0;
		fin_tan = 1'b0;
		beta_go = 1'b0;
		tn = '0;
		case (state_q)
			ST_IDLE: begin
				if (req.valid) begin
					if (stat_in != STAT_OK) begin
						state_d = ST_FIN;
					end else begin
						div_ld = 1'b1;
						div_num_d = NUM_W'(va) << QSH;
						div_den_d = NUM_W'(req.angle_alpha);
						state_d = ST_TQ;
					end
				end
			end
			ST_TQ: begin
				if (div_done) begin
					if (div_quo_q <= t_q) begin
						if (n_q == 4'd1) begin
							fin_tan = 1'b1;
							tn = TAN_CAP;
						end else begin
							div_ld = 1'b1;
							div_num_d = NUM_W'(v_q - 5'd2) << QSH;
							div_den_d = NUM_W'(ang_q);
						end
					end else begin
						div_ld = 1'b1;
						div_num_d = TAN_CAP;
						div_den_d = div_quo_q - t_q;
						state_d = ST_TT;
					end
				end
			end
			ST_TT: begin
				if (div_done) begin
					if (n_q == 4'd1) begin
						fin_tan = 1'b1;
						tn = div_quo_q;
					end else begin
						div_ld = 1'b1;
						div_num_d = NUM_W'(v_q - 5'd2) << QSH;
						div_den_d = NUM_W'(ang_q);
						state_d = ST_TQ;
					end
				end
			end
			ST_DIST: begin
				if (div_done) begin
					if (op_q == 1'b1)
						beta_go = 1'b1;
					else
						state_d = ST_FIN;
				end
			end
			ST_MUL: begin
				if (mul_cnt_q == '0)
					state_d = ST_FIN;
			end
			ST_FIN: begin
				if (rsp_go)
					state_d = ST_IDLE;
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
		if (fin_tan) begin
			if (sel_q) begin
				mul_ld = 1'b1;
				state_d = ST_MUL;
			end else if (tn == '0) begin
				if (op_q == 1'b1)
					beta_go = 1'b1;
				else
					state_d = ST_FIN;
			end else begin
				div_ld = 1'b1;
				div_num_d = NUM_W'(dh_q) << TAN_BITS;
				div_den_d = tn;
				state_d = ST_DIST;
			end
		end
		if (beta_go) begin
			div_ld = 1'b1;
			div_num_d = NUM_W'(vb) << QSH;
			div_den_d = NUM_W'(beta_q);
			state_d = ST_TQ;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			state_q <= ST_IDLE;
		else
			state_q <= state_d;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dh_q <= DH_RESET;
			rsp_valid_q <= 1'b0;
			div_cnt_q <= '0;
			mul_cnt_q <= '0;
		end else begin
			if (cfg.valid)
				dh_q <= cfg.data;
			if (state_q == ST_FIN && rsp_go)
				rsp_valid_q <= 1'b1;
			else if (rsp.ready)
				rsp_valid_q <= 1'b0;
			if (div_ld)
				div_cnt_q <= CNT_W'(NUM_W);
			else if (!div_done)
				div_cnt_q <= div_cnt_q - 1'b1;
			if (mul_ld)
				mul_cnt_q <= MCNT_W'(DIST_W);
			else if (mul_cnt_q != '0)
				mul_cnt_q <= mul_cnt_q - 1'b1;
		end
	end

	// restoring divider, one quotient bit per cycle
	assign rem_sh = {div_rem_q, div_num_q[NUM_W-1]};
	assign rem_dif = rem_sh - {1'b0, div_den_q};

	always_ff @(posedge clk) begin
		if (div_ld) begin
			div_num_q <= div_num_d;
			div_den_q <= div_den_d;
			div_rem_q <= '0;
			div_quo_q <= '0;
		end else if (!div_done) begin
			div_num_q <= {div_num_q[NUM_W-2:0], 1'b0};
			if (!rem_dif[NUM_W]) begin
				div_rem_q <= rem_dif[NUM_W-1:0];
				div_quo_q <= {div_quo_q[NUM_W-2:0], 1'b1};
			end else begin
				div_rem_q <= rem_sh[NUM_W-1:0];
				div_quo_q <= {div_quo_q[NUM_W-2:0], 1'b0};
			end
		end
	end

	// height saturation
	assign p_full = acc_q[PW-1:TAN_BITS];
	assign p48 = (p_full > HGT_MAX_W) ? HGT_MAX : p_full[HGT_W-1:0];
	assign hgt_calc = (p48 > HGT_MAX - HGT_W'(dh_q)) ? HGT_MAX : p48 + HGT_W'(dh_q);

	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				if (req.valid) begin
					op_q <= req.opcode;
					beta_q <= req.angle_beta;
					ang_q <= req.angle_alpha;
					sel_q <= 1'b0;
					n_q <= na;
					v_q <= va;
					t_q <= '0;
					dist_q <= '0;
					hgt_q <= '0;
					stat_q <= stat_in;
				end
			end
			ST_TQ: begin
				if (div_done && div_quo_q <= t_q) begin
					t_q <= TAN_CAP;
					n_q <= n_q - 4'd1;
					v_q <= v_q - 5'd2;
				end
			end
			ST_TT: begin
				if (div_done) begin
					t_q <= div_quo_q;
					n_q <= n_q - 4'd1;
					v_q <= v_q - 5'd2;
				end
			end
			ST_DIST: begin
				if (div_done)
					dist_q <= (div_quo_q > DIST_MAX) ? {DIST_W{1'b1}} :
						div_quo_q[DIST_W-1:0];
			end
			ST_MUL: begin
				if (mul_cnt_q != '0) begin
					acc_q <= {acc_q[PW-2:0], 1'b0} +
						(mul_sh_q[DIST_W-1] ? PW'(t_q) : PW'(0));
					mul_sh_q <= {mul_sh_q[DIST_W-2:0], 1'b0};
				end else begin
					hgt_q <= hgt_calc;
				end
			end
			ST_FIN: begin
				if (rsp_go) begin
					rsp_dist_q <= dist_q;
					rsp_hgt_q <= hgt_q;
					rsp_stat_q <= stat_q;
				end
			end
			default: begin
			end
		endcase
		if (fin_tan && !sel_q && tn == '0)
			dist_q <= {DIST_W{1'b1}};
		if (mul_ld) begin
			mul_sh_q <= dist_q;
			acc_q <= '0;
		end
		if (beta_go) begin
			sel_q <= 1'b1;
			ang_q <= beta_q;
			n_q <= nb;
			v_q <= vb;
			t_q <= '0;
		end
	end

	assign req.ready = state_q == ST_IDLE;
	assign cfg.ready = 1'b1;
	assign rsp.valid = rsp_valid_q;
	assign rsp.distance = rsp_dist_q;
	assign rsp.height = rsp_hgt_q;
	assign rsp.status = rsp_stat_q;

	a_zero_on_err: assert property (@(posedge clk) disable iff (!arst_n)
		rsp.valid && rsp.status != STAT_OK |-> rsp.distance == '0 && rsp.height == '0)
		else $error("nonzero result with error status");
	a_den_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_TT || state_q == ST_DIST) && div_cnt_q == CNT_W'(NUM_W)
		|-> div_den_q != '0)
		else $error("division by zero");
	a_terms_left: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_TQ || state_q == ST_TT |-> n_q != 4'd0)
		else $error("term counter underflow");
	a_mul_beta: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_MUL |-> sel_q && op_q == 1'b1)
		else $error("product without beta phase");
endmodule

// ----- verif/testbench.sv -----
`timescale 1ns / 1ps

module testbench;
	import dhfa_pkg::*;

	localparam logic [OP_W-1:0] OP_DIST = 1'b0;
	localparam logic [OP_W-1:0] OP_HEIGHT = 1'b1;
	localparam int FB = FRAC_BITS_DEF;
	localparam longint unsigned TAN_ONE_SQ = 64'd1 << (2 * TAN_BITS);
	localparam longint unsigned DIST_LIM = (64'd1 << DIST_W) - 1;
	localparam longint unsigned HGT_LIM = (64'd1 << HGT_W) - 1;
	localparam int IDLE_LIMIT = 20000;
	localparam int HOLD_AT = 40000;
	localparam int HOLD_LEN = 4000;

	typedef struct {
		logic [DIST_W-1:0] distance;
		logic [HGT_W-1:0] height;
		status_t status;
	} result_t;

	class dh_scoreboard;
		result_t pending[$];
		logic [DH_W-1:0] dev_height = DH_RESET;
		int errors = 0;
		int n_req = 0;
		int n_rsp = 0;
		int n_stat[3] = '{0, 0, 0};

		function longint unsigned milli_fix(longint unsigned m);
			return (m << FB) / 1000;
		endfunction

		function int terms_for(longint unsigned a);
			longint unsigned brk[9] = '{0, 21, 106, 275, 520, 814, 1121, 1387, 1400};
			int n;
			n = 3;
			for (int i = 0; i < 8; i++) begin
				if (a > milli_fix(brk[i]) && a <= milli_fix(brk[i + 1]))
					break;
				n++;
			end
			return n;
		endfunction

		function longint unsigned tangent(longint unsigned a);
			int n;
			longint unsigned v, t, q;
			n = terms_for(a);
			v = 2 * n - 1;
			t = 0;
			for (int i = n; i > 0; i--) begin
				q = (v << (FB + TAN_BITS)) / a;
				if (q <= t)
					t = TAN_ONE_SQ;
				else
					t = TAN_ONE_SQ / (q - t);
				v -= 2;
			end
			return t;
		endfunction

		function longint unsigned scale_by_tan(longint unsigned d, longint unsigned t);
			longint unsigned hi, lo, dh, dl, p1, frac, whole;
			hi = t >> TAN_BITS;
			lo = t & ((64'd1 << TAN_BITS) - 1);
			dh = d >> 20;
			dl = d & ((64'd1 << 20) - 1);
			p1 = dh * lo;
			frac = (p1 >> (TAN_BITS - 20)) +
				((((p1 & ((64'd1 << (TAN_BITS - 20)) - 1)) << 20) + dl * lo) >> TAN_BITS);
			if (hi != 0 && d > HGT_LIM / hi)
				return HGT_LIM;
			whole = d * hi;
			if (whole > HGT_LIM || frac > HGT_LIM - whole)
				return HGT_LIM;
			return whole + frac;
		endfunction

		function bit angle_valid(longint unsigned a);
			return a != 0 && a <= milli_fix(1400);
		endfunction

		function void note_request(logic [OP_W-1:0] op, logic [ANG_W-1:0] alpha,
				logic [ANG_W-1:0] beta);
			result_t r;
			longint unsigned ta, d, p, devh;
			devh = dev_height;
			r.distance = '0;
			r.height = '0;
			r.status = STAT_OK;
			if (!angle_valid(alpha)) begin
				r.status = STAT_ALPHA;
			end else if (op == OP_HEIGHT && !angle_valid(beta)) begin
				r.status = STAT_BETA;
			end else begin
				ta = tangent(alpha);
				d = (ta == 0) ? DIST_LIM : (devh << TAN_BITS) / ta;
				if (d > DIST_LIM)
					d = DIST_LIM;
				r.distance = DIST_W'(d);
				if (op == OP_HEIGHT) begin
					p = scale_by_tan(d, tangent(beta));
					r.height = HGT_W'((p > HGT_LIM - devh) ? HGT_LIM : p + devh);
				end
			end
			n_req++;
			n_stat[r.status]++;
			pending.push_back(r);
		endfunction

		task report(string what, longint unsigned got, longint unsigned want);
			$display("mismatch %s: got %0d expected %0d (response %0d)", what, got, want,
				n_rsp);
			errors++;
		endtask

		task check_result(logic [DIST_W-1:0] d, logic [HGT_W-1:0] h,
				logic [STAT_W-1:0] s);
			result_t w;
			n_rsp++;
			if (pending.size() == 0) begin
				report("unrequested response", d, 0);
				return;
			end
			w = pending.pop_front();
			if (s !== w.status)
				report("status", s, w.status);
			if (d !== w.distance)
				report("distance", d, w.distance);
			if (h !== w.height)
				report("height", h, w.height);
		endtask
	endclass

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	int cycle = 0;
	int idle_cycles = 0;
	int n_cfg = 0;
	dh_scoreboard sb = new();

	dhfa_cfg_if cfg_if ();
	dhfa_req_if req_if ();
	dhfa_rsp_if rsp_if ();

	distance_height_from_angles uut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg(cfg_if.sink),
		.req(req_if.sink),
		.rsp(rsp_if.source)
	);

	always #2 clk = ~clk;

	initial begin
		cfg_if.valid = 1'b0;
		cfg_if.data = '0;
		req_if.valid = 1'b0;
		req_if.opcode = '0;
		req_if.angle_alpha = '0;
		req_if.angle_beta = '0;
		rsp_if.ready = 1'b0;
	end

	// monitor and watchdog
	always @(posedge clk) begin
		cycle <= cycle + 1;
		if (arst_n) begin
			if (cfg_if.valid && cfg_if.ready) begin
				sb.dev_height = cfg_if.data;
				n_cfg++;
			end
			if (req_if.valid && req_if.ready)
				sb.note_request(req_if.opcode, req_if.angle_alpha, req_if.angle_beta);
			if (rsp_if.valid && rsp_if.ready)
				sb.check_result(rsp_if.distance, rsp_if.height, rsp_if.status);
			if ((req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready) ||
					(cfg_if.valid && cfg_if.ready))
				idle_cycles <= 0;
			else
				idle_cycles <= idle_cycles + 1;
			if (idle_cycles >= IDLE_LIMIT) begin
				$display("timeout: %0d cycles without progress", idle_cycles);
				$display("testbench: done, errors");
				$finish;
			end
		end
	end

	// receiver: changing stall pattern plus one long hold-off
	initial begin
		int mode, left, hold;
		mode = 0;
		left = 0;
		hold = 0;
		@(posedge clk);
		while (!arst_n) @(posedge clk);
		forever begin
			if (cycle == HOLD_AT)
				hold = HOLD_LEN;
			if (left == 0) begin
				mode = $urandom_range(0, 3);
				left = $urandom_range(50, 400);
			end
			left--;
			if (hold > 0) begin
				hold--;
				rsp_if.ready <= 1'b0;
			end else begin
				case (mode)
					0: rsp_if.ready <= 1'b1;
					1: rsp_if.ready <= ($urandom_range(0, 1) == 0);
					2: rsp_if.ready <= ($urandom_range(0, 9) == 0);
					default: rsp_if.ready <= ((cycle % 7) < 3);
				endcase
			end
			@(posedge clk);
		end
	end

	// wait past the current edge first so a request taken at this edge is already noted
	task automatic drain();
		@(posedge clk);
		while (sb.pending.size() != 0) @(posedge clk);
	endtask

	task automatic write_height(logic [DH_W-1:0] value);
		req_if.valid <= 1'b0;
		drain();
		repeat (5) @(posedge clk);
		cfg_if.valid <= 1'b1;
		cfg_if.data <= value;
		@(posedge clk);
		while (!cfg_if.ready) @(posedge clk);
		cfg_if.valid <= 1'b0;
		@(posedge clk);
	endtask

	// valid stays high across back-to-back requests
	task automatic send(logic [OP_W-1:0] op, logic [ANG_W-1:0] alpha,
			logic [ANG_W-1:0] beta);
		req_if.valid <= 1'b1;
		req_if.opcode <= op;
		req_if.angle_alpha <= alpha;
		req_if.angle_beta <= beta;
		@(posedge clk);
		while (!req_if.ready) @(posedge clk);
	endtask

	task automatic pause(int n);
		if (n > 0) begin
			req_if.valid <= 1'b0;
			repeat (n) @(posedge clk);
		end
	endtask

	function automatic logic [ANG_W-1:0] pick_angle(bit noisy);
		int lim;
		lim = (1400 << FB) / 1000;
		if (noisy)
			return ANG_W'($urandom_range(0, (1 << ANG_W) - 1));
		case ($urandom_range(0, 3))
			0: return ANG_W'($urandom_range(1, 2000));
			1: return ANG_W'($urandom_range(lim - 2000, lim));
			default: return ANG_W'($urandom_range(1, lim));
		endcase
	endfunction

	task automatic random_phase(int count);
		int burst;
		bit noisy;
		burst = 0;
		for (int i = 0; i < count; i++) begin
			if (burst == 0) begin
				burst = $urandom_range(1, 20);
				if ($urandom_range(0, 2) != 0)
					pause($urandom_range(1, 40));
			end
			burst--;
			noisy = ($urandom_range(0, 6) == 0);
			send(OP_W'($urandom_range(0, 1)), pick_angle(noisy), pick_angle(noisy));
		end
	endtask

	initial begin
		int lim;
		int brk[7] = '{21, 106, 275, 520, 814, 1121, 1387};
		lim = (1400 << FB) / 1000;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// range edges and status cases
		send(OP_DIST, 0, 0);
		send(OP_DIST, 1, 0);
		send(OP_DIST, ANG_W'(lim), ANG_W'((1 << ANG_W) - 1));
		send(OP_DIST, ANG_W'(lim + 1), 5);
		send(OP_DIST, ANG_W'((1 << ANG_W) - 1), 5);
		send(OP_HEIGHT, 0, 0);
		send(OP_HEIGHT, 1000, 0);
		send(OP_HEIGHT, 1000, ANG_W'(lim + 1));
		send(OP_HEIGHT, ANG_W'(lim), ANG_W'(lim));
		send(OP_HEIGHT, 1, 1);
		send(OP_HEIGHT, 1, ANG_W'(lim));
		pause(1);
		// both sides of every term-count breakpoint
		foreach (brk[i]) begin
			send(OP_HEIGHT, ANG_W'((brk[i] << FB) / 1000),
				ANG_W'((brk[i] << FB) / 1000 + 1));
		end
		write_height(0);
		send(OP_HEIGHT, 30000, 60000);
		send(OP_DIST, 1, 1);
		write_height(DH_W'((1 << DH_W) - 1));
		send(OP_DIST, 1, 1);
		send(OP_HEIGHT, 1, ANG_W'(lim));
		send(OP_HEIGHT, 40000, ANG_W'(lim));

		write_height(DH_W'($urandom_range(0, (1 << DH_W) - 1)));
		random_phase(250);
		// sender waits for every outstanding result
		pause(1);
		drain();
		random_phase(200);
		write_height(DH_W'((1 << DH_W) - 1));
		random_phase(150);
		write_height(0);
		random_phase(100);
		write_height(DH_W'($urandom_range(1, 1 << 20)));
		random_phase(150);
		write_height(DH_RESET);
		random_phase(150);

		req_if.valid <= 1'b0;
		drain();
		repeat (50) @(posedge clk);
		$display("%0d requests (%0d ok, %0d bad alpha, %0d bad beta), %0d responses",
			sb.n_req, sb.n_stat[STAT_OK], sb.n_stat[STAT_ALPHA], sb.n_stat[STAT_BETA],
			sb.n_rsp);
		$display("%0d height writes, %0d mismatches", n_cfg, sb.errors);
		if (sb.errors == 0 && sb.pending.size() == 0)
			$display("testbench: done, clean");
		else
			$display("testbench: done, errors");
		$finish;
	end
endmodule
